[sv/b36_pkg.sv]
`default_nettype none

package b36_pkg;

    // Converted value width; input bits above it are dropped.
    localparam int VALUE_WIDTH = 64;
    // The divider walks the value one byte at a time.
    localparam int NUM_BYTES   = (VALUE_WIDTH + 7) / 8;
    localparam int PAD_WIDTH   = NUM_BYTES * 8;
    localparam int BYTE_CNT_W  = (NUM_BYTES > 1) ? $clog2(NUM_BYTES) : 1;
    localparam int MAX_DIGITS  = 13;
    localparam int DIGIT_CNT_W = $clog2(MAX_DIGITS);
    localparam int RADIX       = 36;
    // floor(x / 9) == (x * DIV9_RECIP) >> 16 for every x below 2304.
    localparam int DIV9_RECIP  = 7282;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [6:0] ASCII_ZERO   = 7'd48;
    localparam logic [6:0] ASCII_ALPHA  = 7'd55;  // 'A' - 10

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CONV,
        BK_EMIT
    } t_back_state;

    // Head of the value queue, as seen by the back end.
    typedef struct packed {
        logic                   valid;
        logic [VALUE_WIDTH-1:0] value;
    } t_q_head;

    typedef struct packed {
        logic [7:0] quot;
        logic [5:0] rem;
    } t_div_step;

    // One byte step of long division by 36: remainder so far on top of the next byte.
    function automatic t_div_step div36_step(input logic [13:0] cur);
        logic [11:0] quarter;
        logic [24:0] prod;
        logic [13:0] back_mul;
        logic [13:0] diff;
        t_div_step   res;
        quarter      = cur[13:2];
        prod         = 25'(quarter) * 25'(DIV9_RECIP);
        res.quot     = prod[23:16];
        back_mul     = 14'(res.quot) * 14'(RADIX);
        diff         = cur - back_mul;
        res.rem      = diff[5:0];
        return res;
    endfunction

    function automatic logic [6:0] digit_to_ascii(input logic [5:0] d);
        logic [6:0] code;
        if (d < 6'd10) begin
            code = ASCII_ZERO + 7'(d);
        end else begin
            code = ASCII_ALPHA + 7'(d);
        end
        return code;
    endfunction

endpackage

`default_nettype wire

[sv/b36_front.sv]
`default_nettype none

module b36_front import b36_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_value,
    output logic             o_busy,
    input  wire logic        i_pop,
    output t_q_head          o_head
);

    logic [VALUE_WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]      r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]      r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]      r_count,  n_count;
    logic                   push;

    assign o_busy = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign push   = i_start && !o_busy;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Drop the bits above the converted width on the way in.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_value[VALUE_WIDTH-1:0];
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.value = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

[sv/b36_back.sv]
`default_nettype none

module b36_back import b36_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_q_head     i_head,
    output logic             o_pop,
    output logic             o_strobe,
    output logic [6:0]       o_character,
    output logic             o_last
);

    t_back_state            r_state, n_state;
    logic [PAD_WIDTH-1:0]   r_val,   n_val;
    logic [5:0]             r_rem,   n_rem;
    logic [BYTE_CNT_W-1:0]  r_byte,  n_byte;
    logic [DIGIT_CNT_W-1:0] r_cnt,   n_cnt;
    logic [DIGIT_CNT_W-1:0] r_idx,   n_idx;
    logic [5:0]             r_dig [MAX_DIGITS];
    logic                   dig_we;
    logic                   r_strobe, n_strobe;
    logic [6:0]             r_char,   n_char;
    logic                   r_last,   n_last;

    t_div_step              step;

    // One byte of long division per cycle, top byte first; quotient bytes
    // shift in at the bottom as dividend bytes leave at the top.
    assign step = div36_step({r_rem, r_val[PAD_WIDTH-1 -: 8]});

    always_comb begin
        n_state  = r_state;
        n_val    = r_val;
        n_rem    = r_rem;
        n_byte   = r_byte;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_strobe = 1'b0;
        n_char   = r_char;
        n_last   = r_last;
        o_pop    = 1'b0;
        dig_we   = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_head.valid) begin
                    o_pop   = 1'b1;
                    n_val   = PAD_WIDTH'(i_head.value);
                    n_rem   = '0;
                    n_byte  = '0;
                    n_cnt   = '0;
                    n_state = BK_CONV;
                end
            end
            BK_CONV: begin
                n_val  = PAD_WIDTH'({r_val, step.quot});
                n_rem  = step.rem;
                n_byte = r_byte + 1'b1;
                if (r_byte == BYTE_CNT_W'(NUM_BYTES - 1)) begin
                    // Quotient complete: keep the remainder as the next digit.
                    dig_we = 1'b1;
                    n_rem  = '0;
                    n_byte = '0;
                    n_cnt  = r_cnt + 1'b1;
                    if (n_val == '0 || r_cnt == DIGIT_CNT_W'(MAX_DIGITS - 1)) begin
                        n_idx   = r_cnt;
                        n_state = BK_EMIT;
                    end
                end
            end
            BK_EMIT: begin
                n_strobe = 1'b1;
                n_char   = digit_to_ascii(r_dig[r_idx]);
                n_last   = (r_idx == '0);
                n_idx    = r_idx - 1'b1;
                if (r_idx == '0) begin
                    if (i_head.valid) begin
                        o_pop   = 1'b1;
                        n_val   = PAD_WIDTH'(i_head.value);
                        n_rem   = '0;
                        n_byte  = '0;
                        n_cnt   = '0;
                        n_state = BK_CONV;
                    end else begin
                        n_state = BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val  <= n_val;
        r_rem  <= n_rem;
        r_byte <= n_byte;
        r_cnt  <= n_cnt;
        r_idx  <= n_idx;
        r_char <= n_char;
        r_last <= n_last;
        if (dig_we) begin
            r_dig[r_cnt] <= step.rem;
        end
    end

    assign o_strobe    = r_strobe;
    assign o_character = r_char;
    assign o_last      = r_last;

endmodule

`default_nettype wire

[sv/binary_to_base36_text_core.sv]
`default_nettype none

// Channel   | Direction | Handshake                    | Payload
// ----------+-----------+------------------------------+---------------------------
// command   | in        | start high, busy low         | i_value[63:0]
// character | out       | o_strobe, one cycle, no stall| o_character[6:0], o_last
//
// A value with k base-36 digits (k = 1..13) is popped from the queue by the back end,
// at once when the back end is idle, then divided in the divide-by-36 unit (one byte
// of the value per cycle, all eight bytes per digit, LSB digit first), then read out
// of the digit buffer MSB first, one character per cycle.
// Characters of one value come on consecutive cycles.
// A two-entry value queue lets start be taken while the back end converts.
// Reset is synchronous, active low, and empties the queue and idles the back end.
// The receiver cannot stall; busy rises only when the queue is full.

module binary_to_base36_text_core import b36_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [63:0] i_value,
    output logic             o_strobe,
    output logic [6:0]       o_character,
    output logic             o_last
);

    t_q_head q_head;
    logic    q_pop;

    // Front end: take the transaction, mask the value, hold it in the queue.
    b36_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_value (i_value),
        .o_busy  (busy),
        .i_pop   (q_pop),
        .o_head  (q_head)
    );

    // Back end: divide into digits, then stream them out most significant first.
    b36_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_strobe    (o_strobe),
        .o_character (o_character),
        .o_last      (o_last)
    );

`ifndef SYNTHESIS
    // A run of characters never breaks before its last one.
    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> o_strobe)
        else $error("character run broken before last");

    // No leading zero: a run of more than one character opens with a nonzero digit.
    a_no_leading_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !$past(o_strobe) && !o_last) |-> (o_character != ASCII_ZERO))
        else $error("leading zero emitted");

    // An accepted transaction leaves the queue non-empty.
    a_push_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> q_head.valid)
        else $error("accepted value missing from queue");

    // The back end pops only a valid queue entry.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_head.valid)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire
